### src/assert_macros.svh
// assert_macros.svh - assertion macros shared by the path search RTL
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied
`define GAP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: when cond holds, prop holds in the same cycle
`define GAP_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

### src/gap_pkg.sv
// gap_pkg.sv - types, constants and helper functions of the grid path search
// No dependencies; imported by gap_ifs, gap_cfg_regs and grid_astar_path_search.
package gap_pkg;

	localparam int ROWS       = 32;
	localparam int COLS       = 32;
	localparam int LIST_DEPTH = 1024;
	localparam int CELLS      = ROWS * COLS;
	localparam int CELL_W     = $clog2(CELLS);
	localparam int LIST_AW    = $clog2(LIST_DEPTH);
	localparam int CNT_W      = LIST_AW + 1;
	localparam int COST_W     = 20;
	localparam logic [COST_W:0] COST_MAX = 21'h0FFFFF;
	localparam int PADDR_W    = 5;
	localparam int PATH_W     = 10;

	// operation codes of an input word
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// status codes of a result word
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_NOTFOUND = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;
	localparam logic [2:0] ST_SAT      = 3'd5;

	// register indexes
	localparam logic [2:0] REG_START_ROW = 3'd0;
	localparam logic [2:0] REG_START_COL = 3'd1;
	localparam logic [2:0] REG_GOAL_ROW  = 3'd2;
	localparam logic [2:0] REG_GOAL_COL  = 3'd3;
	localparam logic [2:0] REG_STRAIGHT  = 3'd4;
	localparam logic [2:0] REG_DIAGONAL  = 3'd5;

	// neighbor steps: up, left, down, right, up-left, down-left, up-right, down-right
	localparam logic [5:0] STEP_DR [8] = '{6'h3F, 6'h00, 6'h01, 6'h00,
		6'h3F, 6'h01, 6'h3F, 6'h01};
	localparam logic [5:0] STEP_DC [8] = '{6'h00, 6'h3F, 6'h00, 6'h01,
		6'h3F, 6'h3F, 6'h01, 6'h01};

	typedef struct packed {
		logic [4:0] start_row;
		logic [4:0] start_col;
		logic [4:0] goal_row;
		logic [4:0] goal_col;
		logic [7:0] straight_cost;
		logic [7:0] diagonal_cost;
	} cfg_t;

	typedef struct packed {
		logic [4:0]         row;
		logic [4:0]         col;
		logic [COST_W-1:0]  g;
		logic [COST_W-1:0]  f;
		logic [LIST_AW-1:0] parent;
	} open_entry_t;

	typedef struct packed {
		logic [4:0]         row;
		logic [4:0]         col;
		logic [LIST_AW-1:0] parent;
	} node_t;

	function automatic logic [CELL_W-1:0] cell_of(logic [4:0] r, logic [4:0] c);
		return CELL_W'(int'(r) * COLS + int'(c));
	endfunction

	// Manhattan distance to the goal times the straight cost
	function automatic logic [13:0] heuristic(logic [4:0] r, logic [4:0] c,
		logic [4:0] gr, logic [4:0] gc, logic [7:0] sc);
		logic [4:0] dr;
		logic [4:0] dc;
		logic [5:0] s;
		dr = (r > gr) ? r - gr : gr - r;
		dc = (c > gc) ? c - gc : gc - c;
		s  = {1'b0, dr} + {1'b0, dc};
		return 14'(s) * 14'(sc);
	endfunction

endpackage

### src/gap_ifs.sv
// gap_ifs.sv - valid/ready channel interfaces for input and result words
// Depends on gap_pkg (field widths).
interface gap_in_if import gap_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [4:0] cell_row;
	logic [4:0] cell_col;
	logic       blocked;
	logic [9:0] path_index;

	modport source (output valid, operation, cell_row, cell_col, blocked, path_index,
		input ready);
	modport sink (input valid, operation, cell_row, cell_col, blocked, path_index,
		output ready);
endinterface

interface gap_out_if import gap_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [10:0] path_length;
	logic [4:0]  path_row;
	logic [4:0]  path_col;
	logic        last_entry;

	modport source (output valid, status, path_length, path_row, path_col, last_entry,
		input ready);
	modport sink (input valid, status, path_length, path_row, path_col, last_entry,
		output ready);
endinterface

### src/gap_ram.sv
// gap_ram.sv - generic single-write, single-read RAM with registered read data
// No dependencies.
module gap_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/gap_cfg_regs.sv
// gap_cfg_regs.sv - APB register file: start, goal and step costs
// Depends on gap_pkg (cfg_t, register indexes).
module gap_cfg_regs import gap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);
	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_row     <= 5'd1;
			cfg_q.start_col     <= 5'd3;
			cfg_q.goal_row      <= 5'd21;
			cfg_q.goal_col      <= 5'd19;
			cfg_q.straight_cost <= 8'd10;
			cfg_q.diagonal_cost <= 8'd14;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_ROW: cfg_q.start_row     <= pwdata[4:0];
				REG_START_COL: cfg_q.start_col     <= pwdata[4:0];
				REG_GOAL_ROW:  cfg_q.goal_row      <= pwdata[4:0];
				REG_GOAL_COL:  cfg_q.goal_col      <= pwdata[4:0];
				REG_STRAIGHT:  cfg_q.straight_cost <= pwdata[7:0];
				REG_DIAGONAL:  cfg_q.diagonal_cost <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_idx)
			REG_START_ROW: prdata = {27'd0, cfg_q.start_row};
			REG_START_COL: prdata = {27'd0, cfg_q.start_col};
			REG_GOAL_ROW:  prdata = {27'd0, cfg_q.goal_row};
			REG_GOAL_COL:  prdata = {27'd0, cfg_q.goal_col};
			REG_STRAIGHT:  prdata = {24'd0, cfg_q.straight_cost};
			REG_DIAGONAL:  prdata = {24'd0, cfg_q.diagonal_cost};
			default:       prdata = 32'd0;
		endcase
	end
endmodule

### src/grid_astar_path_search.sv
// grid_astar_path_search.sv - A* search over a 32x32 8-connected obstacle grid
// Depends on gap_pkg, gap_ifs, gap_ram, gap_cfg_regs and assert_macros.svh.
//
// After reset the block clears the obstacle map and takes no word until then.
// Map writes and op-3 words are answered directly, a path read after the
// registered read of the path RAM. A search first clears the closed marks,
// then for each pop scans the open list once to find the earliest least-f
// entry and a second time to close the gap it leaves (through the single read
// port of the open-list RAM), then checks the eight neighbors of the popped
// cell, skipping those off the grid. When the goal is reached it walks the
// parent chain once to count the path cells and a second time to store them.
// One word is worked on at a time; the next is taken only once the output
// register is empty or its result leaves in the same cycle.
`include "assert_macros.svh"

module grid_astar_path_search import gap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	gap_in_if.sink             in_ch,
	gap_out_if.source          out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_PRD   = 14'b00000000000100,
		S_SCLR  = 14'b00000000001000,
		S_SCAN  = 14'b00000000010000,
		S_SHIFT = 14'b00000000100000,
		S_CRD   = 14'b00000001000000,
		S_CCHK  = 14'b00000010000000,
		S_NBRD  = 14'b00000100000000,
		S_NBCHK = 14'b00001000000000,
		S_PCNT  = 14'b00010000000000,
		S_PCNTW = 14'b00100000000000,
		S_PWR   = 14'b01000000000000,
		S_PWRW  = 14'b10000000000000
	} state_t;

	cfg_t cfg;

	gap_cfg_regs u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	state_t             state_q;
	logic [CELL_W-1:0]  clr_q;
	logic [CNT_W-1:0]   tail_q;
	logic [CNT_W-1:0]   exp_cnt_q;
	logic [CNT_W-1:0]   found_len_q;
	logic [CNT_W-1:0]   scan_i_q;
	logic               rd_s1;
	logic [CNT_W-1:0]   idx_s1;
	logic               have_best_q;
	open_entry_t        best_q;
	logic [CNT_W-1:0]   best_pos_q;
	logic [LIST_AW-1:0] me_q;
	logic [2:0]         dir_q;
	logic [4:0]         nb_row_q;
	logic [4:0]         nb_col_q;
	logic [13:0]        h_q;
	logic [7:0]         cost_q;
	logic [LIST_AW-1:0] pi_q;
	logic [CNT_W-1:0]   pn_q;
	logic [CNT_W-1:0]   pk_q;
	logic [LIST_AW-1:0] rd_idx_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [10:0] out_len_q;
	logic [4:0]  out_row_q;
	logic [4:0]  out_col_q;
	logic        out_last_q;

	// RAM ports
	logic               map_we, map_wdata, map_rdata;
	logic [CELL_W-1:0]  map_waddr, map_raddr;
	logic               cls_we, cls_wdata, cls_rdata;
	logic [CELL_W-1:0]  cls_waddr, cls_raddr;
	logic               open_we;
	logic [LIST_AW-1:0] open_waddr, open_raddr;
	open_entry_t        open_wdata, open_rdata;
	logic               node_we;
	logic [LIST_AW-1:0] node_waddr, node_raddr;
	node_t              node_wdata, node_rdata;
	logic               path_we;
	logic [LIST_AW-1:0] path_waddr, path_raddr;
	logic [PATH_W-1:0]  path_wdata, path_rdata;

	gap_ram #(.DEPTH(CELLS), .WIDTH(1)) u_map (
		.clk, .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(map_raddr), .rdata(map_rdata)
	);
	gap_ram #(.DEPTH(CELLS), .WIDTH(1)) u_closed (
		.clk, .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
		.raddr(cls_raddr), .rdata(cls_rdata)
	);
	gap_ram #(.DEPTH(LIST_DEPTH), .WIDTH($bits(open_entry_t))) u_open (
		.clk, .we(open_we), .waddr(open_waddr), .wdata(open_wdata),
		.raddr(open_raddr), .rdata(open_rdata)
	);
	gap_ram #(.DEPTH(LIST_DEPTH), .WIDTH($bits(node_t))) u_nodes (
		.clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);
	gap_ram #(.DEPTH(LIST_DEPTH), .WIDTH(PATH_W)) u_path (
		.clk, .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
		.raddr(path_raddr), .rdata(path_rdata)
	);

	logic              in_acc;
	logic              wr_inb;
	logic              start_inb;
	logic [13:0]       h_start;
	logic [5:0]        nr6, nc6;
	logic              nb_inb;
	logic              scan_issue;
	logic [COST_W:0]   ng, nf;
	logic              is_goal;

	assign in_ch.ready = (state_q == S_IDLE) && (!out_valid_q || out_ch.ready);
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.path_length = out_len_q;
	assign out_ch.path_row    = out_row_q;
	assign out_ch.path_col    = out_col_q;
	assign out_ch.last_entry  = out_last_q;

	assign wr_inb    = ({1'b0, in_ch.cell_row} < 6'(ROWS)) && ({1'b0, in_ch.cell_col} < 6'(COLS));
	assign start_inb = ({1'b0, cfg.start_row} < 6'(ROWS)) && ({1'b0, cfg.start_col} < 6'(COLS));
	assign h_start   = heuristic(cfg.start_row, cfg.start_col, cfg.goal_row, cfg.goal_col,
		cfg.straight_cost);
	assign nr6       = {1'b0, best_q.row} + STEP_DR[dir_q];
	assign nc6       = {1'b0, best_q.col} + STEP_DC[dir_q];
	assign nb_inb    = (nr6 < 6'(ROWS)) && (nc6 < 6'(COLS));
	assign scan_issue = scan_i_q < tail_q;
	assign ng        = (COST_W+1)'(best_q.g) + (COST_W+1)'(cost_q);
	assign nf        = ng + (COST_W+1)'(h_q);
	assign is_goal   = (best_q.row == cfg.goal_row) && (best_q.col == cfg.goal_col);

	// memory port steering
	always_comb begin
		map_we     = 1'b0;
		map_waddr  = clr_q;
		map_wdata  = 1'b0;
		map_raddr  = cell_of(nr6[4:0], nc6[4:0]);
		cls_we     = 1'b0;
		cls_waddr  = clr_q;
		cls_wdata  = 1'b0;
		cls_raddr  = cell_of(nr6[4:0], nc6[4:0]);
		open_we    = 1'b0;
		open_waddr = tail_q[LIST_AW-1:0];
		open_wdata = '0;
		open_raddr = scan_i_q[LIST_AW-1:0];
		node_we    = 1'b0;
		node_waddr = exp_cnt_q[LIST_AW-1:0];
		node_wdata = '{row: best_q.row, col: best_q.col, parent: best_q.parent};
		node_raddr = pi_q;
		path_we    = 1'b0;
		path_waddr = LIST_AW'(pk_q - CNT_W'(1));
		path_wdata = {node_rdata.row, node_rdata.col};
		path_raddr = in_ch.path_index;
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
			end
			S_IDLE: begin
				map_we    = in_acc && (in_ch.operation == OP_WRITE) && wr_inb;
				map_waddr = cell_of(in_ch.cell_row, in_ch.cell_col);
				map_wdata = in_ch.blocked;
			end
			S_SCLR: begin
				cls_we     = 1'b1;
				open_we    = (clr_q == CELL_W'(CELLS - 1)) && start_inb;
				open_waddr = '0;
				open_wdata = '{row: cfg.start_row, col: cfg.start_col, g: '0,
					f: COST_W'(h_start), parent: '0};
			end
			S_SHIFT: begin
				open_we    = rd_s1;
				open_waddr = LIST_AW'(idx_s1 - CNT_W'(1));
				open_wdata = open_rdata;
			end
			S_CRD: begin
				cls_raddr = cell_of(best_q.row, best_q.col);
			end
			S_CCHK: begin
				cls_we    = !cls_rdata;
				cls_waddr = cell_of(best_q.row, best_q.col);
				cls_wdata = 1'b1;
				node_we   = !cls_rdata && (exp_cnt_q < CNT_W'(LIST_DEPTH));
			end
			S_NBCHK: begin
				open_we    = !map_rdata && !cls_rdata && (ng <= COST_MAX) && (nf <= COST_MAX)
					&& (tail_q < CNT_W'(LIST_DEPTH));
				open_wdata = '{row: nb_row_q, col: nb_col_q, g: ng[COST_W-1:0],
					f: nf[COST_W-1:0], parent: me_q};
			end
			S_PWRW: begin
				path_we = 1'b1;
			end
			default: ;
		endcase
	end

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			tail_q       <= '0;
			exp_cnt_q    <= '0;
			found_len_q  <= '0;
			scan_i_q     <= '0;
			rd_s1        <= 1'b0;
			have_best_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						out_len_q <= found_len_q;
						out_row_q <= '0;
						out_col_q <= '0;
						out_last_q <= 1'b0;
						case (in_ch.operation)
							OP_SEARCH: begin
								found_len_q <= '0;
								tail_q      <= '0;
								exp_cnt_q   <= '0;
								clr_q       <= '0;
								state_q     <= S_SCLR;
							end
							OP_READ: begin
								if ({1'b0, in_ch.path_index} < found_len_q) begin
									rd_idx_q <= in_ch.path_index;
									state_q  <= S_PRD;
								end else begin
									out_valid_q  <= 1'b1;
									out_status_q <= ST_RANGE;
								end
							end
							default: begin
								out_valid_q  <= 1'b1;
								out_status_q <= ST_OK;
							end
						endcase
					end
				end
				S_PRD: begin
					out_valid_q  <= 1'b1;
					out_status_q <= ST_OK;
					out_row_q    <= path_rdata[9:5];
					out_col_q    <= path_rdata[4:0];
					out_last_q   <= (CNT_W'(rd_idx_q) + CNT_W'(1)) == found_len_q;
					state_q      <= S_IDLE;
				end
				S_SCLR: begin
					clr_q <= clr_q + CELL_W'(1);
					if (clr_q == CELL_W'(CELLS - 1)) begin
						if (!start_inb) begin
							out_valid_q  <= 1'b1;
							out_status_q <= ST_NOTFOUND;
							out_len_q    <= '0;
							state_q      <= S_IDLE;
						end else begin
							tail_q      <= CNT_W'(1);
							scan_i_q    <= '0;
							rd_s1       <= 1'b0;
							have_best_q <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				// pass one: earliest entry with the least f
				S_SCAN: begin
					if (tail_q == '0) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_NOTFOUND;
						out_len_q    <= '0;
						state_q      <= S_IDLE;
					end else begin
						rd_s1  <= scan_issue;
						idx_s1 <= scan_i_q;
						if (scan_issue) begin
							scan_i_q <= scan_i_q + CNT_W'(1);
						end
						if (rd_s1 && (!have_best_q || open_rdata.f < best_q.f)) begin
							best_q      <= open_rdata;
							best_pos_q  <= idx_s1;
							have_best_q <= 1'b1;
						end
						if (!scan_issue && !rd_s1) begin
							scan_i_q <= best_pos_q + CNT_W'(1);
							state_q  <= S_SHIFT;
						end
					end
				end
				// pass two: move the entries behind the popped one down by one
				S_SHIFT: begin
					rd_s1  <= scan_issue;
					idx_s1 <= scan_i_q;
					if (scan_issue) begin
						scan_i_q <= scan_i_q + CNT_W'(1);
					end
					if (!scan_issue && !rd_s1) begin
						tail_q  <= tail_q - CNT_W'(1);
						state_q <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= S_CCHK;
				end
				S_CCHK: begin
					if (cls_rdata) begin
						// stale entry: drop and pop again
						scan_i_q    <= '0;
						rd_s1       <= 1'b0;
						have_best_q <= 1'b0;
						state_q     <= S_SCAN;
					end else if (exp_cnt_q >= CNT_W'(LIST_DEPTH)) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OVERFLOW;
						out_len_q    <= '0;
						state_q      <= S_IDLE;
					end else begin
						me_q      <= exp_cnt_q[LIST_AW-1:0];
						exp_cnt_q <= exp_cnt_q + CNT_W'(1);
						if (is_goal) begin
							pi_q    <= exp_cnt_q[LIST_AW-1:0];
							pn_q    <= CNT_W'(1);
							state_q <= S_PCNT;
						end else begin
							dir_q   <= '0;
							state_q <= S_NBRD;
						end
					end
				end
				S_NBRD: begin
					nb_row_q <= nr6[4:0];
					nb_col_q <= nc6[4:0];
					h_q      <= heuristic(nr6[4:0], nc6[4:0], cfg.goal_row, cfg.goal_col,
						cfg.straight_cost);
					cost_q   <= dir_q[2] ? cfg.diagonal_cost : cfg.straight_cost;
					if (nb_inb) begin
						state_q <= S_NBCHK;
					end else if (dir_q == 3'd7) begin
						scan_i_q    <= '0;
						rd_s1       <= 1'b0;
						have_best_q <= 1'b0;
						state_q     <= S_SCAN;
					end else begin
						dir_q <= dir_q + 3'd1;
					end
				end
				S_NBCHK: begin
					if (!map_rdata && !cls_rdata && (ng > COST_MAX || nf > COST_MAX)) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_SAT;
						out_len_q    <= '0;
						state_q      <= S_IDLE;
					end else if (!map_rdata && !cls_rdata && tail_q >= CNT_W'(LIST_DEPTH)) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OVERFLOW;
						out_len_q    <= '0;
						state_q      <= S_IDLE;
					end else begin
						if (!map_rdata && !cls_rdata) begin
							tail_q <= tail_q + CNT_W'(1);
						end
						if (dir_q == 3'd7) begin
							scan_i_q    <= '0;
							rd_s1       <= 1'b0;
							have_best_q <= 1'b0;
							state_q     <= S_SCAN;
						end else begin
							dir_q   <= dir_q + 3'd1;
							state_q <= S_NBRD;
						end
					end
				end
				// count path cells back to the start node
				S_PCNT: begin
					if (pi_q == '0 || pn_q >= CNT_W'(LIST_DEPTH)) begin
						pk_q    <= pn_q;
						pi_q    <= me_q;
						state_q <= S_PWR;
					end else begin
						state_q <= S_PCNTW;
					end
				end
				S_PCNTW: begin
					pi_q    <= node_rdata.parent;
					pn_q    <= pn_q + CNT_W'(1);
					state_q <= S_PCNT;
				end
				// store path cells from the goal backwards
				S_PWR: begin
					if (pk_q == '0) begin
						found_len_q  <= pn_q;
						out_valid_q  <= 1'b1;
						out_status_q <= ST_FOUND;
						out_len_q    <= pn_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_PWRW;
					end
				end
				S_PWRW: begin
					pi_q    <= node_rdata.parent;
					pk_q    <= pk_q - CNT_W'(1);
					state_q <= S_PWR;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GAP_ASSERT(a_tail_bound, tail_q <= CNT_W'(LIST_DEPTH), "open list tail beyond depth")
	`GAP_ASSERT(a_path_fits, found_len_q <= exp_cnt_q, "path longer than expanded nodes")
	`GAP_ASSERT_IMP(a_no_drop, out_valid_q && !out_ch.ready, !in_acc, "word taken while blocked")
	`GAP_ASSERT_IMP(a_shift_below, state_q == S_SHIFT && rd_s1, idx_s1 > best_pos_q, "shift overwrites live entry")
endmodule
